// ===== design/ssic_pkg.sv =====
// Package for the segment / sphere classifier: codes, register indexes,
// default widths and the flag bundle passed between pipeline parts.
// No dependencies.
`default_nettype none

package ssic_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int MODE_BITS      = 2;
   localparam int THR_BITS       = 32;
   localparam int CLASS_BITS     = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CENTER_X   = 3'd0,
      REG_CENTER_Y   = 3'd1,
      REG_CENTER_Z   = 3'd2,
      REG_RADIUS     = 3'd3,
      REG_MODE       = 3'd4,
      REG_TANGENT    = 3'd5
   } csr_index_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_FINITE   = 2'd0,
      MODE_EMPTY    = 2'd1,
      MODE_INFINITE = 2'd2
   } sphere_mode_type;

   localparam logic [CLASS_BITS-1:0] CLASS_NONE    = 2'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_PARTIAL = 2'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_ALL     = 2'd2;

   // Sign tests on the quadratic's coefficients, worked out early and
   // carried alongside the radical.
   typedef struct packed {
      logic point;      // both endpoints equal
      logic point_in;   // C <= 0
      logic b_le0;
      logic c_ge0;
      logic c_le0;
      logic t2a_ge0;    // 2A + B >= 0
      logic t1s_ge0;    // A + B + C >= 0
      logic t1s_le0;
   } class_flags_type;

endpackage

`default_nettype wire

// ===== design/segment_sphere_intersect_classify.sv =====
// Top level of the segment / sphere classifier: configuration registers and
// the three pipeline parts. Depends on ssic_pkg, ssic_front, ssic_disc, ssic_decide.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_ready  start_x..z, end_x..z
//   rsp_     out        rsp_valid / rsp_ready  overlap_class
//   csr_     in         csr_valid / csr_ready  csr_index, csr_data
//
// Each word passes through seven register stages; one word can be taken in every
// cycle unless a stall on the result side holds the pipeline. The depth is set
// by the wide radical, which is built from split partial products.
// Every stage carries its own valid bit and takes a new word whenever it is empty
// or its word moves on, so a stall on the result side backs up stage by stage
// without losing or repeating a word. Reset clears all valid bits and
// returns the registers to an empty sphere.
`default_nettype none

module segment_sphere_intersect_classify import ssic_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int DATA_BITS = (COORD_BITS > THR_BITS) ? COORD_BITS : THR_BITS
) (
   input  wire                         clock,
   input  wire                         reset,

   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire  signed [COORD_BITS-1:0] req_start_x,
   input  wire  signed [COORD_BITS-1:0] req_start_y,
   input  wire  signed [COORD_BITS-1:0] req_start_z,
   input  wire  signed [COORD_BITS-1:0] req_end_x,
   input  wire  signed [COORD_BITS-1:0] req_end_y,
   input  wire  signed [COORD_BITS-1:0] req_end_z,

   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [CLASS_BITS-1:0]       rsp_overlap_class,

   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire  [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [DATA_BITS-1:0]        csr_data
);

   localparam int WB = 2 * COORD_BITS + 4;
   localparam int RW = 2 * WB + 2;

   // Configuration registers. The user must change them only while the pipeline is empty,
   // which the block itself does not enforce; every stage reads them directly.
   logic [COORD_BITS-1:0] cx_ff, cy_ff, cz_ff;
   logic [COORD_BITS-2:0] radius_ff;
   logic [MODE_BITS-1:0]  mode_ff;
   logic [THR_BITS-1:0]   thr_ff;

   logic                  front_valid, front_ready, disc_valid, disc_ready;
   logic signed [WB-1:0]  coef_a, coef_b, coef_c;
   logic                  dzero;
   logic signed [RW-1:0]  rad;
   class_flags_type       flags;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= '0;
         cy_ff     <= '0;
         cz_ff     <= '0;
         radius_ff <= '0;
         mode_ff   <= MODE_EMPTY;
         thr_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CENTER_X: cx_ff     <= csr_data[COORD_BITS-1:0];
            REG_CENTER_Y: cy_ff     <= csr_data[COORD_BITS-1:0];
            REG_CENTER_Z: cz_ff     <= csr_data[COORD_BITS-1:0];
            REG_RADIUS:   radius_ff <= csr_data[COORD_BITS-2:0];
            REG_MODE:     mode_ff   <= csr_data[MODE_BITS-1:0];
            REG_TANGENT:  thr_ff    <= csr_data[THR_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Stages one to three: f = S - C, d = E - S, their products, then A, B, C.
   ssic_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .start     ({req_start_z, req_start_y, req_start_x}),
      .stop      ({req_end_z, req_end_y, req_end_x}),
      .center    ({cz_ff, cy_ff, cx_ff}),
      .radius    (radius_ff),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .a         (coef_a),
      .b         (coef_b),
      .c         (coef_c),
      .dzero     (dzero)
   );

   // Stages four to six: the exact radical and the sign flags that replace
   // the root comparisons.
   ssic_disc #(.COORD_BITS(COORD_BITS)) u_disc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .a         (coef_a),
      .b         (coef_b),
      .c         (coef_c),
      .dzero     (dzero),
      .out_valid (disc_valid),
      .out_ready (disc_ready),
      .rad       (rad),
      .flags     (flags)
   );

   // Stage seven: the class, held in the output register.
   ssic_decide #(.COORD_BITS(COORD_BITS)) u_decide (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (disc_valid),
      .in_ready      (disc_ready),
      .rad           (rad),
      .flags         (flags),
      .mode          (mode_ff),
      .threshold     (thr_ff),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .overlap_class (rsp_overlap_class)
   );

endmodule

`default_nettype wire

// ===== design/ssic_front.sv =====
// First three pipeline stages: difference vectors, products and the
// coefficients A, B and C. Depends on ssic_pkg.
`default_nettype none

module ssic_front import ssic_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int VB = COORD_BITS + 1,
   localparam int PB = 2 * VB,
   localparam int WB = 2 * COORD_BITS + 4
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  wire  [2:0][COORD_BITS-1:0]  start,
   input  wire  [2:0][COORD_BITS-1:0]  stop,
   input  wire  [2:0][COORD_BITS-1:0]  center,
   input  wire  [COORD_BITS-2:0]       radius,
   output logic                        out_valid,
   input  wire                         out_ready,
   output logic signed [WB-1:0]        a,
   output logic signed [WB-1:0]        b,
   output logic signed [WB-1:0]        c,
   output logic                        dzero
);

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   logic signed [VB-1:0] f_in [3];
   logic signed [VB-1:0] d_in [3];
   logic signed [VB-1:0] f_ff [3];
   logic signed [VB-1:0] d_ff [3];
   logic                 dz1_in, dz1_ff, dz2_ff, dz3_ff;

   logic signed [PB-1:0] dd_in [3];
   logic signed [PB-1:0] df_in [3];
   logic signed [PB-1:0] ff_in [3];
   logic signed [PB-1:0] dd_ff [3];
   logic signed [PB-1:0] df_ff [3];
   logic signed [PB-1:0] ff_ff [3];
   logic        [PB-1:0] rr_in, rr_ff;

   logic signed [WB-1:0] a_in, b_in, c_in, a_ff, b_ff, c_ff;

   // A stage takes a new word when it is empty or its word moves on.
   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      dz1_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         f_in[i] = VB'($signed(start[i])) - VB'($signed(center[i]));
         d_in[i] = VB'($signed(stop[i])) - VB'($signed(start[i]));
         if (d_in[i] != '0) begin
            dz1_in = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dd_in[i] = PB'(d_ff[i]) * PB'(d_ff[i]);
         df_in[i] = PB'(d_ff[i]) * PB'(f_ff[i]);
         ff_in[i] = PB'(f_ff[i]) * PB'(f_ff[i]);
      end
      rr_in = PB'(radius) * PB'(radius);
   end

   always_comb begin
      a_in = WB'(dd_ff[0]) + WB'(dd_ff[1]) + WB'(dd_ff[2]);
      b_in = (WB'(df_ff[0]) + WB'(df_ff[1]) + WB'(df_ff[2])) <<< 1;
      c_in = WB'(ff_ff[0]) + WB'(ff_ff[1]) + WB'(ff_ff[2])
             - WB'($signed({1'b0, rr_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         f_ff   <= f_in;
         d_ff   <= d_in;
         dz1_ff <= dz1_in;
      end
      if (en2) begin
         dd_ff  <= dd_in;
         df_ff  <= df_in;
         ff_ff  <= ff_in;
         rr_ff  <= rr_in;
         dz2_ff <= dz1_ff;
      end
      if (en3) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         c_ff   <= c_in;
         dz3_ff <= dz2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign a         = a_ff;
   assign b         = b_ff;
   assign c         = c_ff;
   assign dzero     = dz3_ff;

endmodule

`default_nettype wire

// ===== design/ssic_disc.sv =====
// Stages four to six: the radical B*B - 4*A*C from split partial products,
// and the coefficient sign flags. Depends on ssic_pkg.
`default_nettype none

module ssic_disc import ssic_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int WB = 2 * COORD_BITS + 4,
   localparam int LB = WB / 2,
   localparam int SB = LB + 1,
   localparam int PP = 2 * SB,
   localparam int RW = 2 * WB + 2
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  wire  signed [WB-1:0]    a,
   input  wire  signed [WB-1:0]    b,
   input  wire  signed [WB-1:0]    c,
   input  wire                     dzero,
   output logic                    out_valid,
   input  wire                     out_ready,
   output logic signed [RW-1:0]    rad,
   output class_flags_type         flags
);

   logic v4_ff, v5_ff, v6_ff;
   logic en4, en5, en6;

   logic signed [SB-1:0] ah, al, bh, bl, ch, cl;
   logic signed [PP-1:0] bhh_in, bhl_in, bll_in, ahch_in, ahcl_in, alch_in, alcl_in;
   logic signed [PP-1:0] bhh_ff, bhl_ff, bll_ff, ahch_ff, ahcl_ff, alch_ff, alcl_ff;
   logic signed [WB-1:0] t2a, t1s;
   class_flags_type      fl4_in, fl4_ff, fl5_ff, fl6_ff;

   logic signed [RW-1:0] bb_in, ac4_in, bb_ff, ac4_ff, rad_in, rad_ff;

   assign en6      = !v6_ff || out_ready;
   assign en5      = !v5_ff || en6;
   assign en4      = !v4_ff || en5;
   assign in_ready = en4;

   // Each coefficient is cut into a signed upper half and an unsigned lower half.
   always_comb begin
      ah = SB'($signed(a[WB-1:LB]));
      al = $signed({1'b0, a[LB-1:0]});
      bh = SB'($signed(b[WB-1:LB]));
      bl = $signed({1'b0, b[LB-1:0]});
      ch = SB'($signed(c[WB-1:LB]));
      cl = $signed({1'b0, c[LB-1:0]});
      bhh_in  = PP'(bh) * PP'(bh);
      bhl_in  = PP'(bh) * PP'(bl);
      bll_in  = PP'(bl) * PP'(bl);
      ahch_in = PP'(ah) * PP'(ch);
      ahcl_in = PP'(ah) * PP'(cl);
      alch_in = PP'(al) * PP'(ch);
      alcl_in = PP'(al) * PP'(cl);

      t2a = (a <<< 1) + b;
      t1s = a + b + c;
      fl4_in.point    = dzero;
      fl4_in.point_in = (c <= 0);
      fl4_in.b_le0    = (b <= 0);
      fl4_in.c_ge0    = (c >= 0);
      fl4_in.c_le0    = (c <= 0);
      fl4_in.t2a_ge0  = (t2a >= 0);
      fl4_in.t1s_ge0  = (t1s >= 0);
      fl4_in.t1s_le0  = (t1s <= 0);
   end

   always_comb begin
      bb_in  = (RW'(bhh_ff) <<< (2 * LB)) + (RW'(bhl_ff) <<< (LB + 1)) + RW'(bll_ff);
      ac4_in = ((RW'(ahch_ff) <<< (2 * LB)) + ((RW'(ahcl_ff) + RW'(alch_ff)) <<< LB)
                + RW'(alcl_ff)) <<< 2;
      rad_in = bb_ff - ac4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en4) begin
            v4_ff <= in_valid;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
         if (en6) begin
            v6_ff <= v5_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         bhh_ff  <= bhh_in;
         bhl_ff  <= bhl_in;
         bll_ff  <= bll_in;
         ahch_ff <= ahch_in;
         ahcl_ff <= ahcl_in;
         alch_ff <= alch_in;
         alcl_ff <= alcl_in;
         fl4_ff  <= fl4_in;
      end
      if (en5) begin
         bb_ff  <= bb_in;
         ac4_ff <= ac4_in;
         fl5_ff <= fl4_ff;
      end
      if (en6) begin
         rad_ff <= rad_in;
         fl6_ff <= fl5_ff;
      end
   end

   assign out_valid = v6_ff;
   assign rad       = rad_ff;
   assign flags     = fl6_ff;

endmodule

`default_nettype wire

// ===== design/ssic_decide.sv =====
// Final stage: tangent window test and class selection into the output
// register. Depends on ssic_pkg.
`default_nettype none

module ssic_decide import ssic_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int RW = 4 * COORD_BITS + 10
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  wire  signed [RW-1:0]    rad,
   input  wire  class_flags_type   flags,
   input  wire  [MODE_BITS-1:0]    mode,
   input  wire  [THR_BITS-1:0]     threshold,
   output logic                    out_valid,
   input  wire                     out_ready,
   output logic [CLASS_BITS-1:0]   overlap_class
);

   logic                  v7_ff;
   logic                  en7;
   logic signed [RW-1:0]  thr_pos, thr_neg;
   logic                  tangent;
   logic [CLASS_BITS-1:0] class_in, class_ff;

   assign en7      = !v7_ff || out_ready;
   assign in_ready = en7;

   always_comb begin
      thr_pos = $signed(RW'(threshold));
      thr_neg = -thr_pos;
      // |rad| < threshold without forming the magnitude.
      tangent = (rad < thr_pos) && (rad > thr_neg);

      if (mode == MODE_INFINITE) begin
         class_in = CLASS_ALL;
      end else if (mode != MODE_FINITE) begin
         class_in = CLASS_NONE;
      end else if (flags.point) begin
         class_in = flags.point_in ? CLASS_ALL : CLASS_NONE;
      end else if (tangent) begin
         class_in = (flags.b_le0 && flags.t2a_ge0) ? CLASS_PARTIAL : CLASS_NONE;
      end else if (rad < 0) begin
         class_in = CLASS_NONE;
      end else if (flags.b_le0 && flags.c_ge0 && flags.t2a_ge0 && flags.t1s_ge0) begin
         class_in = CLASS_ALL;
      end else if ((flags.t2a_ge0 || flags.t1s_le0) && (flags.b_le0 || flags.c_le0)) begin
         class_in = CLASS_PARTIAL;
      end else begin
         class_in = CLASS_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en7) begin
         v7_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         class_ff <= class_in;
      end
   end

   assign out_valid     = v7_ff;
   assign overlap_class = class_ff;

endmodule

`default_nettype wire
